FILE: rtl/imsp_pkg.sv
`timescale 1ns / 1ps

package imsp_pkg;

  // Fixed field widths of the stream items and registers
  localparam int unsigned FieldW   = 32;
  localparam int unsigned GapW     = 16;
  localparam int unsigned LenW     = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic [GapW-1:0] MergeGapRst = GapW'(50);
  localparam logic [LenW-1:0] PieceLenRst = LenW'(5000);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgMergeGap    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPieceLength = 1'b1;

  // Request to the shared add/subtract/compare unit
  typedef struct packed {
    logic [FieldW-1:0] a;
    logic [FieldW-1:0] b;
    logic [FieldW-1:0] c;
    logic              sub;
  } alu_req_t;

  // Response of the shared unit
  typedef struct packed {
    logic [FieldW-1:0] res;
    logic              gt;
  } alu_rsp_t;

  // One result item
  typedef struct packed {
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] stop;
    logic              ovf;
    logic              fin;
  } piece_t;

endpackage

FILE: rtl/imsp_alu.sv
`timescale 1ns / 1ps

module imsp_alu (
  input  imsp_pkg::alu_req_t req_i,
  output imsp_pkg::alu_rsp_t rsp_o
);
  import imsp_pkg::*;

  logic [FieldW-1:0] b_op;
  logic [FieldW:0]   sum;

  // sub: a - b, gt when a >= b and the difference is above c
  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign sum  = {1'b0, req_i.a} + {1'b0, b_op} + {{FieldW{1'b0}}, req_i.sub};

  assign rsp_o.res = sum[FieldW-1:0];
  assign rsp_o.gt  = req_i.sub & sum[FieldW] & (sum[FieldW-1:0] > req_i.c);

endmodule

FILE: rtl/imsp_ctrl.sv
`timescale 1ns / 1ps

module imsp_ctrl #(
  parameter int unsigned MAX_PIECES = 32,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [imsp_pkg::FieldW-1:0]            in_start_i,
  input  logic [imsp_pkg::FieldW-1:0]            in_end_i,
  input  logic                                   in_last_i,
  input  logic [imsp_pkg::GapW-1:0]              gap_i,
  input  logic [imsp_pkg::LenW-1:0]              len_i,
  output imsp_pkg::alu_req_t                     alu_req_o,
  input  imsp_pkg::alu_rsp_t                     alu_rsp_i,
  input  logic                                   out_free_i,
  output logic                                   out_we_o,
  output imsp_pkg::piece_t                       out_piece_o
);
  import imsp_pkg::*;

  localparam int unsigned CW   = (COORD_BITS < FieldW) ? COORD_BITS : FieldW;
  localparam int unsigned CntW = $clog2(MAX_PIECES + 1);
  localparam logic [CntW-1:0] CntCap = CntW'(MAX_PIECES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_EXTEND, ST_FLUSH, ST_CMP, ST_ADD, ST_LAST
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   start_q, end_q;
  logic            last_q;
  logic [CW-1:0]   rs_q, re_q;
  logic            open_q;
  logic [CW-1:0]   s_q, e_q;
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic            flush_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // Operand selection for the shared unit
  always_comb begin
    alu_req_o = '0;
    unique case (state_q)
      ST_CHECK: begin
        alu_req_o.a   = FieldW'(start_q);
        alu_req_o.b   = FieldW'(re_q);
        alu_req_o.c   = FieldW'(gap_i);
        alu_req_o.sub = 1'b1;
      end
      ST_EXTEND: begin
        alu_req_o.a   = FieldW'(end_q);
        alu_req_o.b   = FieldW'(re_q);
        alu_req_o.sub = 1'b1;
      end
      ST_CMP: begin
        alu_req_o.a   = FieldW'(e_q);
        alu_req_o.b   = FieldW'(s_q);
        alu_req_o.c   = len_i;
        alu_req_o.sub = 1'b1;
      end
      ST_ADD: begin
        alu_req_o.a = FieldW'(s_q);
        alu_req_o.b = len_i;
      end
      default: alu_req_o = '0;
    endcase
  end

  // Piece write toward the output register
  always_comb begin
    out_we_o    = 1'b0;
    out_piece_o = '0;
    unique case (state_q)
      ST_ADD: begin
        out_we_o          = out_free_i;
        out_piece_o.start = FieldW'(s_q);
        out_piece_o.stop  = FieldW'(alu_rsp_i.res[CW-1:0]);
      end
      ST_LAST: begin
        out_we_o          = out_free_i;
        out_piece_o.start = FieldW'(s_q);
        out_piece_o.stop  = FieldW'(e_q);
        out_piece_o.ovf   = ovf_q;
        out_piece_o.fin   = flush_q | ~last_q;
      end
      default: out_we_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= '0;
      end_q   <= '0;
      last_q  <= 1'b0;
      rs_q    <= '0;
      re_q    <= '0;
      open_q  <= 1'b0;
      s_q     <= '0;
      e_q     <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            start_q <= in_start_i[CW-1:0];
            end_q   <= in_end_i[CW-1:0];
            last_q  <= in_last_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!open_q) begin
            rs_q    <= start_q;
            re_q    <= end_q;
            open_q  <= 1'b1;
            state_q <= ST_FLUSH;
          end else if (alu_rsp_i.gt) begin
            s_q     <= rs_q;
            e_q     <= re_q;
            cnt_q   <= '0;
            flush_q <= 1'b0;
            state_q <= ST_CMP;
          end else begin
            state_q <= ST_EXTEND;
          end
        end
        ST_EXTEND: begin
          if (alu_rsp_i.gt) begin
            re_q <= end_q;
          end
          state_q <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (last_q) begin
            s_q     <= rs_q;
            e_q     <= re_q;
            cnt_q   <= '0;
            flush_q <= 1'b1;
            state_q <= ST_CMP;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_CMP: begin
          if (alu_rsp_i.gt && (cnt_q < CntCap)) begin
            state_q <= ST_ADD;
          end else begin
            ovf_q   <= alu_rsp_i.gt;
            state_q <= ST_LAST;
          end
        end
        ST_ADD: begin
          if (out_free_i) begin
            s_q     <= alu_rsp_i.res[CW-1:0];
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_CMP;
          end
        end
        ST_LAST: begin
          if (out_free_i) begin
            if (flush_q) begin
              open_q  <= 1'b0;
              rs_q    <= '0;
              re_q    <= '0;
              state_q <= ST_IDLE;
            end else begin
              rs_q    <= start_q;
              re_q    <= end_q;
              state_q <= ST_FLUSH;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/interval_merge_and_split.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                tuser           tlast
// s_axis    in         interval_start, interval_end      -               group_last
// m_axis    out        piece_start, piece_end            piece_overflow  final_piece
// cfg       in         index 0 merge_gap, 1 piece_length (write only)
//
// One item is in flight at a time, on one shared 32-bit add/subtract/compare unit.
// Merging into the open region steps through accept, merge check, extend and flush
// check; an item that opens or closes a region skips the extend step. Each piece
// adds a compare, then a piece write; a close plus group_last emits both.
// A stall on m_axis holds the piece write; s_axis stays low until the item's last
// piece sits in the output register. Reset closes the region, loads 50 and 5000.

module interval_merge_and_split #(
  parameter int unsigned MAX_PIECES = 32,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // interval_start [31:0], interval_end [63:32]
  input  logic [2*imsp_pkg::FieldW-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // piece_start [31:0], piece_end [63:32]
  output logic [2*imsp_pkg::FieldW-1:0]     m_axis_tdata,
  // piece_overflow [0]
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [imsp_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [imsp_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import imsp_pkg::*;

  logic [GapW-1:0] gap_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] len_eff;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic   out_we;
  logic   out_free;
  piece_t out_piece;
  piece_t out_q;
  logic   out_valid_q;

  // Configuration: take a write whenever enabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= MergeGapRst;
      len_q <= PieceLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgMergeGap:    gap_q <= cfg_wdata_i[GapW-1:0];
        CfgPieceLength: len_q <= cfg_wdata_i[LenW-1:0];
        default:        gap_q <= gap_q;
      endcase
    end
  end

  // Treat a zero piece length as one
  assign len_eff = (len_q == '0) ? LenW'(1) : len_q;

  imsp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  imsp_ctrl #(
    .MAX_PIECES (MAX_PIECES),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_start_i  (s_axis_tdata[FieldW-1:0]),
    .in_end_i    (s_axis_tdata[2*FieldW-1:FieldW]),
    .in_last_i   (s_axis_tlast),
    .gap_i       (gap_q),
    .len_i       (len_eff),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .out_free_i  (out_free),
    .out_we_o    (out_we),
    .out_piece_o (out_piece)
  );

  // Output register: load a piece when the slot empties this cycle
  assign out_free = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_we) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_q <= out_piece;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.stop, out_q.start};
  assign m_axis_tuser  = out_q.ovf;
  assign m_axis_tlast  = out_q.fin;

  // An accepted item keeps the block busy for at least the merge check
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an item");

  // A capped piece always runs forward to the region end
  a_ovf_piece_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[2*FieldW-1:FieldW] > m_axis_tdata[FieldW-1:0]))
    else $error("overflow piece does not extend past its start");

  // A new piece only appears once the previous one was taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !out_we)
    else $error("output register overwritten while stalled");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import imsp_pkg::*;

  localparam int unsigned MaxPieces    = 32;
  localparam int unsigned CoordBits    = 32;
  localparam int unsigned PhaseItems   = 56;
  localparam int unsigned NumPhases    = 8;
  // An item that closes nothing keeps the sequencer busy through its merge and flush checks.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit   = 4000;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  // One row of the directed table: an interval item or a register write.
  // For a write, a holds the register index and b the value.
  typedef struct packed {
    row_kind_e         kind;
    logic [FieldW-1:0] a;
    logic [FieldW-1:0] b;
    logic              last;
    logic              typed;
    piece_t            want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic [2*FieldW-1:0]   s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*FieldW-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_addr_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;

  // Shadow copy of the block: registers and the open region
  logic [GapW-1:0]       gap_reg;
  logic [LenW-1:0]       plen_reg;
  logic [FieldW-1:0]     region_lo;
  logic [FieldW-1:0]     region_hi;
  logic                  region_live;

  piece_t                fresh_pieces[$];  // pieces caused by the item just taken
  piece_t                pieces_due[$];    // pieces still to come out, oldest first
  stim_row_t             directed_rows[$];

  int unsigned           fail_count = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           src_idle_pct = 0;
  int unsigned           sink_stall_pct = 0;

  piece_t                seen_piece;
  piece_t                due_piece;

  always #2 clk_i = ~clk_i;

  interval_merge_and_split #(
    .MAX_PIECES(MaxPieces),
    .COORD_BITS(CoordBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic piece_t pc(input logic [FieldW-1:0] lo, input logic [FieldW-1:0] hi,
                                input logic ovf, input logic fin);
    piece_t p;
    p.start = lo;
    p.stop  = hi;
    p.ovf   = ovf;
    p.fin   = fin;
    return p;
  endfunction

  // Clamp a wide sum to the top coordinate instead of letting it wrap.
  function automatic logic [FieldW-1:0] sat_coord(input logic [63:0] v);
    return (v > 64'h0000_0000_FFFF_FFFF) ? '1 : v[FieldW-1:0];
  endfunction

  // Cut the open region into pieces of at most plen_reg, remainder last.
  // Past the cap, the final piece runs to the region end and carries ovf.
  function automatic void cut_region();
    logic [63:0] step;
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned count;
    logic        capped;
    step   = (plen_reg == '0) ? 64'd1 : 64'(plen_reg);
    lo     = 64'(region_lo);
    hi     = 64'(region_hi);
    count  = 0;
    capped = 1'b0;
    while (hi > lo && hi - lo > step) begin
      if (count >= MaxPieces - 1) begin
        capped = 1'b1;
        break;
      end
      fresh_pieces = {fresh_pieces,
                      pc(lo[FieldW-1:0], lo[FieldW-1:0] + step[FieldW-1:0], 1'b0, 1'b0)};
      count++;
      lo = lo + step;
    end
    // A region with end not past its start lands here unchanged.
    fresh_pieces = {fresh_pieces, pc(lo[FieldW-1:0], hi[FieldW-1:0], capped, 1'b0)};
  endfunction

  // Take one interval into the shadow region and collect the pieces it causes.
  function automatic void merge_interval(input logic [FieldW-1:0] lo,
                                         input logic [FieldW-1:0] hi, input logic last);
    piece_t p;
    if (!region_live) begin
      // Nothing open: the interval always opens a region.
      region_lo   = lo;
      region_hi   = hi;
      region_live = 1'b1;
    end else if (lo > region_hi && lo - region_hi > 32'(gap_reg)) begin
      cut_region();
      region_lo = lo;
      region_hi = hi;
    end else if (hi > region_hi) begin
      region_hi = hi;
    end
    if (last) begin
      cut_region();
      region_live = 1'b0;
      region_lo   = '0;
      region_hi   = '0;
    end
    // Mark the last piece of this item.
    if (fresh_pieces.size() > 0) begin
      p = fresh_pieces.pop_back();
      p.fin = 1'b1;
      fresh_pieces = {fresh_pieces, p};
    end
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [FieldW-1:0] a,
                                  input logic [FieldW-1:0] b, input logic last,
                                  input logic typed, input piece_t want);
    stim_row_t r;
    r.kind  = kind;
    r.a     = a;
    r.b     = b;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    directed_rows = {directed_rows, r};
  endfunction

  // Offer one interval item, optionally after random idle cycles. Enter and
  // leave at a falling edge; the item is taken at the rising edge with tready.
  task automatic send_interval(input logic [FieldW-1:0] lo, input logic [FieldW-1:0] hi,
                               input logic last, input logic typed, input piece_t want);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    end
    s_axis_tdata  <= {hi, lo};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    merge_interval(lo, hi, last);
    if (typed) begin
      // Row carries its own expectation; drop the computed one.
      fresh_pieces.delete();
      pieces_due = {pieces_due, want};
    end else begin
      while (fresh_pieces.size() > 0) pieces_due = {pieces_due, fresh_pieces.pop_front()};
    end
    @(negedge clk_i);
  endtask

  // Lower tvalid, wait for every due piece, then let extra cycles pass.
  task automatic hold_until_drained(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pieces_due.size() > 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CfgMergeGap) begin
      gap_reg = val[GapW-1:0];
    end else begin
      plen_reg = val[LenW-1:0];
    end
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each piece taken from the block with the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_piece = pc(m_axis_tdata[FieldW-1:0], m_axis_tdata[2*FieldW-1:FieldW],
                      m_axis_tuser[0], m_axis_tlast);
      if (pieces_due.size() == 0) begin
        fail_count++;
        $display("%0t: piece with none due: start %h end %h ovf %b fin %b", $time,
                 seen_piece.start, seen_piece.stop, seen_piece.ovf, seen_piece.fin);
      end else begin
        due_piece = pieces_due.pop_front();
        if (seen_piece !== due_piece) begin
          fail_count++;
          $display("%0t: piece mismatch: expected start %h end %h ovf %b fin %b, got start %h end %h ovf %b fin %b",
                   $time, due_piece.start, due_piece.stop, due_piece.ovf, due_piece.fin,
                   seen_piece.start, seen_piece.stop, seen_piece.ovf, seen_piece.fin);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no item moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t         r;
    int unsigned       phase;
    int unsigned       sent;
    int unsigned       n_grp;
    int unsigned       eff;
    logic              paused;
    logic              last;
    logic [63:0]       cur;
    logic [63:0]       far;
    logic [63:0]       span;
    logic [FieldW-1:0] lo;
    logic [FieldW-1:0] hi;
    logic [GapW-1:0]   g;
    logic [LenW-1:0]   l;

    // Drive every input to a known value and hold reset.
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    gap_reg       = MergeGapRst;
    plen_reg      = PieceLenRst;
    region_lo     = '0;
    region_hi     = '0;
    region_live   = 1'b0;
    paused        = 1'b0;

    // Directed table, first under the reset values of the registers.
    add_row(RowItem, 32'd100, 32'd200, 1'b1, 1'b1, pc(32'd100, 32'd200, 1'b0, 1'b1));
    // Empty region and end below start come out as one piece, unchanged.
    add_row(RowItem, 32'd0, 32'd0, 1'b1, 1'b1, pc(32'd0, 32'd0, 1'b0, 1'b1));
    add_row(RowItem, 32'd500, 32'd100, 1'b1, 1'b1, pc(32'd500, 32'd100, 1'b0, 1'b1));
    // Gap of exactly merge_gap merges, one more closes; an inner interval extends nothing.
    add_row(RowItem, 32'd1000, 32'd2000, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd2050, 32'd3000, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd3051, 32'd3100, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd3000, 32'd3050, 1'b1, 1'b0, '0);
    // Closing item with group_last: two regions at once.
    add_row(RowItem, 32'd10000, 32'd10100, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd20000, 32'd20100, 1'b1, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'd12000, 1'b1, 1'b0, '0);
    add_row(RowItem, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b1,
            pc(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0, 1'b1));
    add_row(RowItem, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    // No gap allowed: adjacent merges, one past closes.
    add_row(RowWrite, 32'(CfgMergeGap), 32'd0, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd100, 32'd200, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd201, 32'd300, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd300, 32'd400, 1'b1, 1'b0, '0);
    // Widest gap merges across 65535.
    add_row(RowWrite, 32'(CfgMergeGap), 32'd65535, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'd10, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd65545, 32'd65600, 1'b1, 1'b0, '0);
    // Unit pieces: exactly at the cap, one past it, and two items merged into one capped region.
    add_row(RowWrite, 32'(CfgPieceLength), 32'd1, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'd32, 1'b1, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'd33, 1'b1, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'd100, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd1000, 32'd1100, 1'b1, 1'b0, '0);
    // Zero piece length acts as one.
    add_row(RowWrite, 32'(CfgPieceLength), 32'd0, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd7, 32'd9, 1'b1, 1'b0, '0);
    // Longest piece takes the full span in one.
    add_row(RowWrite, 32'(CfgPieceLength), 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(RowItem, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, pc(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table with no idling on either side.
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == RowWrite) begin
        hold_until_drained(SettleCycles);
        write_reg(r.a[CfgIdxW-1:0], r.b);
      end else begin
        send_interval(r.a, r.b, r.last, r.typed, r.want);
      end
    end

    // Random phases: new register setting and idling mode in each.
    for (phase = 0; phase < NumPhases; phase++) begin
      hold_until_drained(SettleCycles);
      case (phase)
        0: begin
          g = 16'd50;
          l = 32'd5000;
        end
        1: begin
          g = 16'd0;
          l = 32'd1;
        end
        2: begin
          g = 16'hFFFF;
          l = 32'hFFFF_FFFF;
        end
        3: begin
          g = 16'($urandom_range(0, 65535));
          l = 32'd0;
        end
        4: begin
          g = 16'd300;
          l = 32'd200;
        end
        5: begin
          g = 16'd0;
          l = 32'($urandom_range(1, 100));
        end
        6: begin
          g = 16'($urandom_range(0, 65535));
          l = 32'd2000;
        end
        default: begin
          g = 16'd5000;
          l = $urandom;
        end
      endcase
      write_reg(CfgMergeGap, 32'(g));
      write_reg(CfgPieceLength, l);

      case (phase % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 56;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 56;
        end
        default: begin
          src_idle_pct   = 30;
          sink_stall_pct = 30;
        end
      endcase

      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(99) < 12) begin
          // Noise: unsorted coordinates, end below start, stray flush.
          send_interval($urandom, $urandom, 1'($urandom_range(1)), 1'b0, '0);
          sent++;
        end else begin
          // Well-formed group: starts ascend, steps overlap, fall within
          // the gap or jump past it; the final interval flushes.
          n_grp = $urandom_range(1, 8);
          if ($urandom_range(7) == 0) begin
            cur = 64'(32'hFFFF_FFFF - $urandom_range(0, 100000));
          end else begin
            cur = 64'($urandom);
          end
          far = cur;
          for (int unsigned k = 0; k < n_grp; k++) begin
            eff = (plen_reg == '0) ? 1 : ((plen_reg > 20000) ? 20000 : plen_reg);
            case ($urandom_range(19))
              0:       span = 64'($urandom);
              1, 2:    span = 64'($urandom_range(0, 40 * eff));
              default: span = 64'($urandom_range(0, 3 * eff));
            endcase
            lo   = cur[FieldW-1:0];
            hi   = sat_coord(cur + span);
            last = (k == n_grp - 1) || ($urandom_range(99) < 4);
            if (64'(hi) > far) begin
              far = 64'(hi);
            end
            send_interval(lo, hi, last, 1'b0, '0);
            sent++;
            // Once, let every due piece come out before sending on.
            if (phase == 1 && !paused && sent >= PhaseItems / 2) begin
              hold_until_drained(0);
              paused = 1'b1;
            end
            case ($urandom_range(2))
              0:       cur = cur + 64'($urandom_range(0, 32'(far - cur)));
              1:       cur = far + 64'($urandom_range(0, 32'(gap_reg)));
              default: cur = far + 64'(gap_reg) + 64'($urandom_range(1, 2000));
            endcase
            cur = 64'(sat_coord(cur));
          end
        end
      end
    end

    // Drain and let the sequencer settle before the verdict.
    hold_until_drained(SettleCycles);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/imsp_pkg.sv
rtl/imsp_alu.sv
rtl/imsp_ctrl.sv
rtl/interval_merge_and_split.sv
tb/tb_top.sv
